// File: design/pscs_pkg.sv
// shared types, register and step codes for the proximity scaled chase and sweep block
// no dependencies
`default_nettype none
package pscs_pkg;

  localparam int LED_COUNT_DEF    = 8;
  localparam int PWM_LED_MASK_DEF = 15;
  localparam int LED_OUTS         = 8;

  localparam int DIV_NW = 40;
  localparam int DIV_DW = 32;

  localparam logic [2:0] REG_NEAR       = 3'd0;
  localparam logic [2:0] REG_FAR        = 3'd1;
  localparam logic [2:0] REG_SPEED_MAX  = 3'd2;
  localparam logic [2:0] REG_SWEEP_BASE = 3'd3;
  localparam logic [2:0] REG_CHASE_BASE = 3'd4;
  localparam logic [2:0] REG_GLOW       = 3'd5;
  localparam logic [2:0] REG_ANGLE_LOW  = 3'd6;
  localparam logic [2:0] REG_ANGLE_HIGH = 3'd7;

  localparam logic [3:0] OP_DIST  = 4'd0;
  localparam logic [3:0] OP_SPEED = 4'd1;
  localparam logic [3:0] OP_PS    = 4'd2;
  localparam logic [3:0] OP_RS    = 4'd3;
  localparam logic [3:0] OP_OFF   = 4'd4;
  localparam logic [3:0] OP_PC    = 4'd5;
  localparam logic [3:0] OP_RC    = 4'd6;
  localparam logic [3:0] OP_LEDA  = 4'd7;
  localparam logic [3:0] OP_LEDB  = 4'd8;
  localparam logic [3:0] OP_LEDC  = 4'd9;

  typedef struct packed {
    logic       capture;
    logic       setup;
    logic       finish;
    logic       load_out;
    logic [3:0] op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic led_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: design/proximity_scaled_chase_and_sweep.sv
// top level: one request per millisecond tick, one result per request
// each request runs its divisions one after another on the shared 40-step divider
// (six divisions for speed, periods, phases and sweep offset, one per LED); one at a time
// the next request is taken while a finished result waits in the output register
// synchronous active-high reset: registers to defaults, time zero, held distance 1600
// uses pscs_pkg, pscs_ctrl and pscs_dp
`default_nettype none
module proximity_scaled_chase_and_sweep #(
  parameter int LED_COUNT    = pscs_pkg::LED_COUNT_DEF,
  parameter int PWM_LED_MASK = pscs_pkg::PWM_LED_MASK_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [15:0]  s_tdata,  // echo_us
  input  wire logic [0:0]   s_tuser,  // echo_present
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [111:0]      m_tdata,  // servo_a_angle, servo_b_angle, led_0..led_7,
                                      // distance_now, speed_now, zero fill
  input  wire logic         wr_en,
  input  wire logic [2:0]   wr_index,
  input  wire logic [15:0]  wr_data
);
  import pscs_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  pscs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pscs_dp #(
    .LED_COUNT    (LED_COUNT),
    .PWM_LED_MASK (PWM_LED_MASK)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .in_present (s_tuser[0]),
    .in_us      (s_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .result     (m_tdata)
  );

endmodule
`default_nettype wire

// File: design/pscs_div.sv
// restoring divider, one quotient bit per cycle
// uses pscs_pkg
`default_nettype none
module pscs_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [pscs_pkg::DIV_NW-1:0] num,
  input  wire logic [pscs_pkg::DIV_DW-1:0] den,
  output logic                           done,
  output logic [pscs_pkg::DIV_NW-1:0]    quo,
  output logic [pscs_pkg::DIV_DW-1:0]    rem
);
  import pscs_pkg::*;

  logic [DIV_DW:0] part;
  logic [DIV_DW:0] shifted;
  logic [5:0]      cnt;
  logic            busy;

  assign shifted = {part[DIV_DW-1:0], quo[DIV_NW-1]};
  assign rem = part[DIV_DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part <= '0;
      quo  <= num;
    end else if (busy) begin
      if (shifted >= {1'b0, den}) begin
        part <= shifted - {1'b0, den};
        quo  <= {quo[DIV_NW-2:0], 1'b1};
      end else begin
        part <= shifted;
        quo  <= {quo[DIV_NW-2:0], 1'b0};
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) start |=> busy && !done)
    else $error("divider did not start");

endmodule
`default_nettype wire

// File: design/pscs_dp.sv
// datapath: config registers, held distance, time, divider operands and results
// uses pscs_pkg and pscs_div
`default_nettype none
module pscs_dp #(
  parameter int LED_COUNT    = pscs_pkg::LED_COUNT_DEF,
  parameter int PWM_LED_MASK = pscs_pkg::PWM_LED_MASK_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire logic [2:0]          wr_index,
  input  wire logic [15:0]         wr_data,
  input  wire logic                in_present,
  input  wire logic [15:0]         in_us,
  input  wire pscs_pkg::ctrl_cmd_t cmd,
  output pscs_pkg::dp_stat_t       stat,
  output logic [111:0]             result
);
  import pscs_pkg::*;

  localparam int LED_LOOP = (LED_COUNT < LED_OUTS) ? LED_COUNT : LED_OUTS;
  localparam logic [7:0] PWM_BITS = 8'(PWM_LED_MASK);
  // 80 * ceil(2^32 / 291); gives exactly floor of echo*80/291 for 16-bit echoes
  localparam logic [30:0] DIST_RECIP = 31'd1180747040;

  logic [14:0] near_limit, far_limit;
  logic [11:0] speed_max, glow_width;
  logic [15:0] sweep_base, chase_base;
  logic [7:0]  angle_low, angle_high;

  logic [31:0] time_ms;
  logic [14:0] held;
  logic        echo_p;
  logic [15:0] echo_us;
  logic [11:0] speed;
  logic [15:0] ps, pc, rc, rs;
  logic [7:0]  ang_a, ang_b;
  logic [7:0]  leds [LED_OUTS];
  logic [2:0]  led_i;
  logic [20:0] ta, tb, tot, x;
  logic [27:0] dgl;

  logic [DIV_NW-1:0] num;
  logic [DIV_DW-1:0] den;
  logic              div_start, div_done;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] rem;

  logic [11:0] smax;
  logic        ordered;
  logic [14:0] dcl;
  logic [7:0]  span;
  logic [16:0] two_r, two_ps, tri_n;
  logic [8:0]  a_sum;
  logic [7:0]  a_new, b_raw, b_new;
  logic [20:0] xa, xw;
  logic [28:0] x256;
  logic        led_off;
  logic [27:0] diff;
  logic [7:0]  v_raw, v_new;
  logic [46:0] dist_prod;

  pscs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo),
    .rem   (rem)
  );

  // start in the cycle after setup so the divider loads the new operands
  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= cmd.setup && cmd.op != OP_DIST && cmd.op != OP_LEDA &&
                   cmd.op != OP_LEDB;
    end
  end

  assign stat.div_done = div_done;
  assign stat.led_last = (led_i == 3'(LED_LOOP - 1));

  always_comb begin
    dist_prod = 47'(echo_us) * 47'(DIST_RECIP);
    smax    = (speed_max < 12'd256) ? 12'd256 : speed_max;
    ordered = far_limit > near_limit;
    if (held < near_limit) dcl = near_limit;
    else if (held > far_limit) dcl = far_limit;
    else dcl = held;
    span   = (angle_high >= angle_low) ? angle_high - angle_low : 8'd0;
    two_r  = {rs, 1'b0};
    two_ps = {ps, 1'b0};
    tri_n  = (two_r < {1'b0, ps}) ? two_r : two_ps - two_r;
    a_sum  = {1'b0, angle_low} + quo[8:0];
    a_new  = (a_sum > 9'd180) ? 8'd180 : a_sum[7:0];
    b_raw  = (angle_high >= a_new) ? angle_high - a_new : 8'd0;
    b_new  = (b_raw > 8'd180) ? 8'd180 : b_raw;
    xa     = (ta >= tb) ? ta - tb : tb - ta;
    xw     = (tot - xa < xa) ? tot - xa : xa;
    x256   = {x, 8'b0};
    led_off = x256 >= {1'b0, dgl};
    diff   = led_off ? 28'd0 : dgl - x256[27:0];
    if (glow_width == 12'd0) v_raw = (x == 21'd0) ? 8'd255 : 8'd0;
    else if (led_off) v_raw = 8'd0;
    else v_raw = quo[7:0];
    if (!PWM_BITS[led_i]) v_new = (v_raw >= 8'd128) ? 8'd255 : 8'd0;
    else v_new = v_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit <= 15'd160;
      far_limit  <= 15'd1600;
      speed_max  <= 12'd768;
      sweep_base <= 16'd4000;
      chase_base <= 16'd2000;
      glow_width <= 12'd384;
      angle_low  <= 8'd0;
      angle_high <= 8'd180;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_NEAR:       near_limit <= wr_data[14:0];
        REG_FAR:        far_limit  <= wr_data[14:0];
        REG_SPEED_MAX:  speed_max  <= wr_data[11:0];
        REG_SWEEP_BASE: sweep_base <= wr_data;
        REG_CHASE_BASE: chase_base <= wr_data;
        REG_GLOW:       glow_width <= wr_data[11:0];
        REG_ANGLE_LOW:  angle_low  <= wr_data[7:0];
        REG_ANGLE_HIGH: angle_high <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms <= '0;
      held    <= 15'd1600;
    end else begin
      if (cmd.load_out) time_ms <= time_ms + 32'd1;
      if (cmd.setup && cmd.op == OP_DIST && echo_p && echo_us != 16'd0) begin
        held <= dist_prod[46:32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      echo_p  <= in_present;
      echo_us <= in_us;
      led_i   <= '0;
      for (int k = 0; k < LED_OUTS; k++) leds[k] <= '0;
    end
    if (cmd.setup) begin
      unique case (cmd.op)
        OP_SPEED: begin
          num <= 40'(far_limit - dcl) * 40'(smax - 12'd256);
          den <= ordered ? 32'(far_limit - near_limit) : 32'd1;
        end
        OP_PS: begin
          num <= 40'({sweep_base, 8'b0});
          den <= 32'(speed);
        end
        OP_RS: begin
          num <= 40'(time_ms);
          den <= 32'(ps);
        end
        OP_OFF: begin
          num <= 40'(tri_n) * 40'(span);
          den <= 32'(ps);
        end
        OP_PC: begin
          num <= 40'({chase_base, 8'b0});
          den <= 32'(speed);
        end
        OP_RC: begin
          num <= 40'(time_ms);
          den <= 32'(pc);
        end
        OP_LEDA: begin
          ta  <= 21'(led_i) * 21'(pc);
          tb  <= 21'(rc) * 21'(LED_COUNT);
          tot <= 21'(pc) * 21'(LED_COUNT);
        end
        OP_LEDB: begin
          x   <= xw;
          dgl <= 28'(pc) * 28'(glow_width);
        end
        OP_LEDC: begin
          num <= 40'({diff, 8'b0}) - 40'(diff);
          den <= (glow_width == 12'd0) ? 32'd1 : 32'(dgl);
        end
        default: ;
      endcase
    end
    if (cmd.finish) begin
      unique case (cmd.op)
        OP_SPEED: begin
          if (ordered) speed <= 12'd256 + quo[11:0];
          else speed <= (held <= near_limit) ? smax : 12'd256;
        end
        OP_PS:  ps <= (quo < 40'd200) ? 16'd200 : quo[15:0];
        OP_RS:  rs <= rem[15:0];
        OP_OFF: begin
          ang_a <= a_new;
          ang_b <= b_new;
        end
        OP_PC:  pc <= (quo < 40'd150) ? 16'd150 : quo[15:0];
        OP_RC:  rc <= rem[15:0];
        OP_LEDC: begin
          leds[led_i] <= v_new;
          led_i       <= led_i + 3'd1;
        end
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      result <= {5'd0, speed, held, leds[7], leds[6], leds[5], leds[4],
                 leds[3], leds[2], leds[1], leds[0], ang_b, ang_a};
    end
  end

endmodule
`default_nettype wire

// File: design/pscs_ctrl.sv
// controller: sequences the divider and non-divider steps of one tick and the output handshake
// uses pscs_pkg
`default_nettype none
module pscs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  input  wire pscs_pkg::dp_stat_t stat,
  output pscs_pkg::ctrl_cmd_t     cmd
);
  import pscs_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ISSUE  = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0] state, state_next;
  logic [3:0] phase, phase_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    cmd.op     = phase;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          phase_next  = OP_DIST;
          state_next  = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.setup = 1'b1;
        if (phase == OP_DIST || phase == OP_LEDA || phase == OP_LEDB) begin
          phase_next = phase + 4'd1;
        end else begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (stat.div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_ISSUE;
        if (phase == OP_LEDC) begin
          if (stat.led_last) state_next = ST_OUT;
          else phase_next = OP_LEDA;
        end else begin
          phase_next = phase + 4'd1;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= OP_DIST;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (cmd.load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_ISSUE && phase == OP_DIST)
    else $error("request not started at first step");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT && stat.div_done |=> state == ST_FINISH)
    else $error("divider result missed");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && m_tvalid && !m_tready |=> state == ST_OUT && m_tvalid)
    else $error("pending result overwritten");

endmodule
`default_nettype wire
